@@ design/i2cm_pkg.sv @@
// Shared types and constants of the I2C master bit engine.
package i2cm_pkg;

	localparam int DIV_W = 16;

	localparam logic [2:0] FUNC_NONE     = 3'd0;
	localparam logic [2:0] FUNC_START_WR = 3'd1;
	localparam logic [2:0] FUNC_START_RD = 3'd2;
	localparam logic [2:0] FUNC_WRITE    = 3'd3;
	localparam logic [2:0] FUNC_READ     = 3'd4;
	localparam logic [2:0] FUNC_STOP     = 3'd5;

	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRETCH_EN  = 4'd1;

	localparam logic [15:0] HALF_PERIOD_RST = 16'd250;
	localparam logic [3:0] LAST_DATA_BIT = 4'd7;
	localparam logic [3:0] ACK_SLOT = 4'd8;

	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_START = 5'b00010,
		PH_TX    = 5'b00100,
		PH_RX    = 5'b01000,
		PH_STOP  = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [2:0] func;
		logic [6:0] target_address;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_line;
		logic       scl_line;
	} cmd_t;

	typedef struct packed {
		logic       scl_pull_low;
		logic       sda_pull_low;
		logic       cmd_ready;
		logic       cmd_done;
		logic [7:0] rx_byte;
		logic       slave_acked;
	} res_t;

endpackage

@@ design/i2cm_cmd_if.sv @@
// Command channel: one beat per bus clock tick.
interface i2cm_cmd_if;
	import i2cm_pkg::*;
	logic valid;
	logic ready;
	cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/i2cm_res_if.sv @@
// Result channel: one beat per accepted command beat.
interface i2cm_res_if;
	import i2cm_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/i2cm_cfg_if.sv @@
// Configuration write channel.
interface i2cm_cfg_if;
	import i2cm_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/i2cm_core.sv @@
// Bus sequencer state and the next-state logic for one tick.
module i2cm_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  i2cm_pkg::cmd_t  cmd,
	input  logic [15:0]     half_period,
	input  logic            stretch_enable,
	output i2cm_pkg::res_t  res,
	output logic            idle
);
	import i2cm_pkg::*;

	phase_t           phase_q, phase_d;
	logic [3:0]       bit_q, bit_d;
	logic [DIV_W-1:0] tick_q, tick_d;
	logic [1:0]       quarter_q, quarter_d;
	logic [7:0]       shift_q, shift_d;
	logic             ack_send_q, ack_send_d;
	logic             ack_flag_q, ack_flag_d;
	logic             scl_q, scl_d;
	logic             sda_q, sda_d;
	logic [7:0]       rx_q, rx_d;

	logic             ready;
	logic             done;
	logic             hold;
	logic             end_step;
	logic [DIV_W-1:0] hp;
	logic [DIV_W-1:0] tick_inc;
	logic [7:0]       shift_new;

	always_comb begin
		phase_d    = phase_q;
		bit_d      = bit_q;
		tick_d     = tick_q;
		quarter_d  = quarter_q;
		shift_d    = shift_q;
		ack_send_d = ack_send_q;
		ack_flag_d = ack_flag_q;
		scl_d      = scl_q;
		sda_d      = sda_q;
		rx_d       = rx_q;
		done       = 1'b0;
		end_step   = 1'b0;
		shift_new  = shift_q;
		ready      = (phase_q == PH_IDLE);

		hp = DIV_W'(half_period);
		if (hp == '0) begin
			hp = DIV_W'(1);
		end
		tick_inc = tick_q + DIV_W'(1);
		// A slave holding SCL low freezes the high half of the bit.
		hold = (quarter_q == 2'd1) && stretch_enable && !cmd.scl_line;

		if (ready) begin
			tick_d    = '0;
			quarter_d = 2'd0;
			case (cmd.func)
				FUNC_START_WR, FUNC_START_RD: begin
					phase_d = PH_START;
					shift_d = {cmd.target_address, (cmd.func == FUNC_START_RD)};
					sda_d   = 1'b0;
				end
				FUNC_WRITE: begin
					phase_d = PH_TX;
					shift_d = cmd.tx_byte;
					bit_d   = 4'd0;
					sda_d   = !cmd.tx_byte[7];
				end
				FUNC_READ: begin
					phase_d    = PH_RX;
					shift_d    = 8'd0;
					ack_send_d = cmd.send_ack;
					bit_d      = 4'd0;
					sda_d      = 1'b0;
				end
				FUNC_STOP: begin
					phase_d = PH_STOP;
					scl_d   = 1'b1;
					sda_d   = 1'b1;
				end
				default: begin
				end
			endcase
		end else if (!hold) begin
			tick_d = tick_inc;
			if (tick_inc >= hp || tick_inc == '0) begin
				tick_d   = '0;
				end_step = 1'b1;
			end
		end

		if (end_step) begin
			case (phase_q)
				PH_START: begin
					case (quarter_q)
						2'd0: begin
							scl_d     = 1'b0;
							quarter_d = 2'd1;
						end
						2'd1: begin
							sda_d     = 1'b1;
							quarter_d = 2'd2;
						end
						2'd2: begin
							scl_d     = 1'b1;
							quarter_d = 2'd3;
						end
						default: begin
							phase_d   = PH_TX;
							bit_d     = 4'd0;
							quarter_d = 2'd0;
							sda_d     = !shift_q[7];
						end
					endcase
				end
				PH_TX, PH_RX: begin
					if (quarter_q == 2'd0) begin
						scl_d     = 1'b0;
						quarter_d = 2'd1;
					end else begin
						if (bit_q < ACK_SLOT) begin
							shift_new = {shift_q[6:0], (phase_q == PH_RX) && cmd.sda_line};
						end else if (phase_q == PH_TX) begin
							ack_flag_d = !cmd.sda_line;
						end else begin
							rx_d = shift_q;
						end
						shift_d = shift_new;
						scl_d   = 1'b1;
						if (bit_q >= ACK_SLOT) begin
							if (phase_q == PH_RX) begin
								sda_d = 1'b0;
							end
							phase_d   = PH_IDLE;
							quarter_d = 2'd0;
							bit_d     = 4'd0;
							done      = 1'b1;
						end else begin
							bit_d     = bit_q + 4'd1;
							quarter_d = 2'd0;
							if (bit_q < LAST_DATA_BIT) begin
								sda_d = (phase_q == PH_TX) && !shift_new[7];
							end else begin
								// Entering the ACK slot: a write releases SDA to listen.
								sda_d = (phase_q == PH_RX) && ack_send_q;
							end
						end
					end
				end
				PH_STOP: begin
					case (quarter_q)
						2'd0: begin
							scl_d     = 1'b0;
							quarter_d = 2'd1;
						end
						2'd1: begin
							sda_d     = 1'b0;
							quarter_d = 2'd2;
						end
						default: begin
							phase_d   = PH_IDLE;
							quarter_d = 2'd0;
							done      = 1'b1;
						end
					endcase
				end
				default: begin
					phase_d   = PH_IDLE;
					quarter_d = 2'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			bit_q      <= 4'd0;
			tick_q     <= '0;
			quarter_q  <= 2'd0;
			shift_q    <= 8'd0;
			ack_send_q <= 1'b0;
			ack_flag_q <= 1'b0;
			scl_q      <= 1'b0;
			sda_q      <= 1'b0;
			rx_q       <= 8'd0;
		end else if (step) begin
			phase_q    <= phase_d;
			bit_q      <= bit_d;
			tick_q     <= tick_d;
			quarter_q  <= quarter_d;
			shift_q    <= shift_d;
			ack_send_q <= ack_send_d;
			ack_flag_q <= ack_flag_d;
			scl_q      <= scl_d;
			sda_q      <= sda_d;
			rx_q       <= rx_d;
		end
	end

	assign res.scl_pull_low = scl_d;
	assign res.sda_pull_low = sda_d;
	assign res.cmd_ready    = ready;
	assign res.cmd_done     = done;
	assign res.rx_byte      = rx_d;
	assign res.slave_acked  = ack_flag_d;
	assign idle             = ready;

endmodule

@@ design/i2c_master_bit_engine_unit.sv @@
// Top level of the I2C master bit engine: channels, configuration and result register.
//
// Each beat on cmd is one tick of the bus timer. It carries a command code
// (used only when the engine is idle), its operands and the sampled SDA and
// SCL wire levels. Every accepted cmd beat yields exactly one res beat with
// the open-drain pull-down enables, cmd_ready, a one-tick cmd_done pulse,
// the last received byte and the last slave ACK.
// The result of a beat is in the result register on the edge that accepts it.
// The engine takes one beat per cycle while res is not stalled; the sequencer
// state and the result register update together in a single pass.
// cfg writes half_period (index 0) and stretch_enable (index 1); the port is
// always ready and should be written only while the engine is idle.
// Reset returns to idle with both lines released, half_period at 250 and
// stretching enabled. When the res receiver stalls with a beat held, cmd
// is not ready, so no tick is lost; bus timing then follows the beat rate.
module i2c_master_bit_engine_unit (
	input logic       clk,
	input logic       arst_n,
	i2cm_cmd_if.sink  cmd,
	i2cm_res_if.source res,
	i2cm_cfg_if.sink  cfg
);
	import i2cm_pkg::*;

	logic [15:0] half_period_q;
	logic        stretch_en_q;
	logic        res_valid_q;
	res_t        res_data_q;
	res_t        core_res;
	logic        core_idle;
	logic        step;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= HALF_PERIOD_RST;
			stretch_en_q  <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_HALF_PERIOD: half_period_q <= cfg.data;
				REG_STRETCH_EN:  stretch_en_q  <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	assign cmd.ready = !res_valid_q || res.ready;
	assign step      = cmd.valid && cmd.ready;

	i2cm_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.cmd            (cmd.data),
		.half_period    (half_period_q),
		.stretch_enable (stretch_en_q),
		.res            (core_res),
		.idle           (core_idle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_data_q <= core_res;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_data_q;

	// A finished command always leaves the engine idle for the next tick.
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && core_res.cmd_done) |=> core_idle)
		else $error("engine not idle after cmd_done");

	// Done can only be reported on a tick that was not taking a command.
	a_done_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.data.cmd_done) |-> !res.data.cmd_ready)
		else $error("cmd_done and cmd_ready in the same beat");

	// A held result must block new command beats.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res.ready) |-> !cmd.ready)
		else $error("command accepted while result stalled");

endmodule
